/* hdl/lrush_pkg.sv */
// ---------------------------------------------------------------------------
// lrush_pkg
// shared constants for the lru shelf update block
// ---------------------------------------------------------------------------
package lrush_pkg;

    localparam int SLOT_COUNT_DEF = 8;   // default number of stack slots
    localparam int ID_W           = 8;   // identifier width
    localparam int SHOWN_SLOTS    = 8;   // slots packed into the result word
    localparam int OCC_W          = 4;   // width of the reported occupancy
    localparam int OCC_MAX        = 15;  // clamp value of the reported occupancy

    localparam logic [ID_W-1:0] EMPTY_ID = '0;

endpackage

/* hdl/lrush_next.sv */
// ---------------------------------------------------------------------------
// lrush_next
// next-state logic of the lru stack: compare, prefix mask and shift network
// ---------------------------------------------------------------------------
module lrush_next
    import lrush_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int CNT_W      = $clog2(SLOT_COUNT + 1)
)
(
    input  logic [SLOT_COUNT-1:0][ID_W-1:0] slots,
    input  logic [CNT_W-1:0]                fill,
    input  logic [ID_W-1:0]                 id,
    output logic [SLOT_COUNT-1:0][ID_W-1:0] slots_next,
    output logic [CNT_W-1:0]                fill_next,
    output logic                            hit
);

    logic [SLOT_COUNT-1:0] match;
    logic [SLOT_COUNT-1:0] at_or_above;
    logic [SLOT_COUNT-1:0] shift;
    logic                  full;
    logic                  active;
    logic [CNT_W-1:0]      top_idx;

    // per-slot compare, only occupied slots count
    always_comb
    begin
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            match[k] = (slots[k] == id) && (CNT_W'(k) < fill);
        end
    end

    // slots at or above the first match
    always_comb
    begin
        at_or_above[0] = match[0];
        for (int k = 1; k < SLOT_COUNT; k++)
        begin
            at_or_above[k] = at_or_above[k-1] | match[k];
        end
    end

    assign active  = (id != EMPTY_ID);
    assign hit     = active && (|match);
    assign full    = (fill == CNT_W'(SLOT_COUNT));
    assign top_idx = (hit || full) ? fill - CNT_W'(1) : fill;

    always_comb
    begin
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            shift[k] = hit ? at_or_above[k] : full;
        end
    end

    // shift network with insertion at the top slot
    always_comb
    begin
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            if (!active)
            begin
                slots_next[k] = slots[k];
            end
            else if (CNT_W'(k) == top_idx)
            begin
                slots_next[k] = id;
            end
            else if (shift[k])
            begin
                slots_next[k] = (k + 1 < SLOT_COUNT) ? slots[(k + 1) % SLOT_COUNT] : EMPTY_ID;
            end
            else
            begin
                slots_next[k] = slots[k];
            end
        end
    end

    assign fill_next = (active && !hit && !full) ? fill + CNT_W'(1) : fill;

endmodule

/* hdl/lru_shelf_update_top.sv */
// ---------------------------------------------------------------------------
// lru_shelf_update_top
// eight-slot least-recently-used stack of 8-bit identifiers
// ---------------------------------------------------------------------------
// Each accepted transaction carries one identifier and produces exactly one
// result transaction with the packed stack (byte 0 oldest, zero byte empty),
// the occupancy and a hit flag. A hit moves the identifier to the top of the
// occupied slots, a miss appends it, and a miss on a full stack drops the
// oldest entry. A zero identifier leaves the stack unchanged and reports it.
// The path from input to result is one input register, then the
// compare/shift logic feeding the result register. The stack state updates
// in the same cycle the result is loaded, so one transaction is taken every
// cycle as long as the result side keeps up; the result register decouples
// the two sides for one pending result.
// ---------------------------------------------------------------------------
module lru_shelf_update_top
    import lrush_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ID_W-1:0]             book_id,
    // result channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [SHOWN_SLOTS*ID_W-1:0] shelf_slots,
    output logic [OCC_W-1:0]            occupied,
    output logic                        was_hit
);

    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    // input register
    logic                  in_valid_reg;
    logic [ID_W-1:0]       in_id_reg;

    // stack state
    logic [SLOT_COUNT-1:0][ID_W-1:0] slot_reg;
    logic [SLOT_COUNT-1:0][ID_W-1:0] slot_next;
    logic [CNT_W-1:0]                fill_reg;
    logic [CNT_W-1:0]                fill_next;
    logic                            hit_next;

    // result register
    logic                        out_valid_reg;
    logic [SHOWN_SLOTS*ID_W-1:0] out_slots_reg;
    logic [SHOWN_SLOTS*ID_W-1:0] out_slots_next;
    logic [OCC_W-1:0]            out_occ_reg;
    logic [OCC_W-1:0]            out_occ_next;
    logic                        out_hit_reg;

    logic                        advance;
    logic [CNT_W+OCC_W-1:0]      fill_wide;

    // the held item moves on when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    lrush_next #(
        .SLOT_COUNT (SLOT_COUNT),
        .CNT_W      (CNT_W)
    ) u_next (
        .slots      (slot_reg),
        .fill       (fill_reg),
        .id         (in_id_reg),
        .slots_next (slot_next),
        .fill_next  (fill_next),
        .hit        (hit_next)
    );

    // pack the shown slots, missing slots read as zero
    always_comb
    begin
        for (int k = 0; k < SHOWN_SLOTS; k++)
        begin
            if (k < SLOT_COUNT)
            begin
                out_slots_next[k*ID_W +: ID_W] = slot_next[k % SLOT_COUNT];
            end
            else
            begin
                out_slots_next[k*ID_W +: ID_W] = EMPTY_ID;
            end
        end
    end

    // occupancy clamped to the field width
    assign fill_wide    = {{OCC_W{1'b0}}, fill_next};
    assign out_occ_next = (fill_wide > (CNT_W+OCC_W)'(OCC_MAX)) ? OCC_W'(OCC_MAX)
                                                                : fill_wide[OCC_W-1:0];

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fill_reg      <= '0;
            slot_reg      <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                fill_reg      <= fill_next;
                slot_reg      <= slot_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_id_reg <= book_id;
        end
        if (advance)
        begin
            out_slots_reg <= out_slots_next;
            out_occ_reg   <= out_occ_next;
            out_hit_reg   <= hit_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign shelf_slots = out_slots_reg;
    assign occupied    = out_occ_reg;
    assign was_hit     = out_hit_reg;

endmodule

/* verif/tb_lru_shelf_update_top.sv */
// ---------------------------------------------------------------------------
// tb_lru_shelf_update_top
// self-checking bench for the eight-slot lru shelf update block
// ---------------------------------------------------------------------------
// A tracker object keeps its own copy of the lru stack. It predicts the
// packed slots, the occupancy and the hit flag for every accepted access,
// and it checks each accepted result against the oldest prediction. The
// stimulus starts with a short directed warm-up that covers the zero id, a
// hit at the oldest, middle and newest slot, appends and evictions. It then
// sends random segments. Most segments draw from a small id pool, so hits
// and evictions keep happening. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb_lru_shelf_update_top
    import lrush_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_COUNT   = SLOT_COUNT_DEF;
    localparam int SLOTS_W      = SHOWN_SLOTS * ID_W;
    localparam int RANDOM_HITS  = 1370;   // nonzero random accesses to send
    localparam int IDLE_LIMIT   = 2000;   // cycles with no transaction before giving up
    localparam int SETTLE_TICKS = 12;     // quiet cycles after the last result

    // one predicted result transaction
    typedef struct {
        logic [SLOTS_W-1:0] slots;
        logic [OCC_W-1:0]   occ;
        logic               hit;
    } shelf_view_t;

    // ------------------------------------------------------------------
    // shelf tracker: shadow lru stack plus queue of predicted results
    // ------------------------------------------------------------------
    class shelf_tracker;
        logic [ID_W-1:0] stack_ids [SLOT_COUNT];
        int              fill;
        shelf_view_t     expected_views [$];
        int              error_count;

        function new();
            foreach (stack_ids[k])
                stack_ids[k] = EMPTY_ID;
            fill        = 0;
            error_count = 0;
        endfunction

        function int pending();
            return expected_views.size();
        endfunction

        // update the shadow stack for one accepted access, queue its result
        function void note_access(logic [ID_W-1:0] id);
            shelf_view_t view;
            int          pos;
            int          k;
            view.slots = '0;
            view.hit   = 1'b0;
            if (id != EMPTY_ID)
            begin
                pos = fill;
                for (k = 0; k < fill && pos == fill; k++)
                    if (stack_ids[k] == id)
                        pos = k;
                if (pos < fill)
                begin
                    // hit: close the gap, id becomes newest
                    view.hit = 1'b1;
                    for (k = pos; k < fill - 1; k++)
                        stack_ids[k] = stack_ids[k + 1];
                    stack_ids[fill - 1] = id;
                end
                else if (fill < SLOT_COUNT)
                begin
                    stack_ids[fill] = id;
                    fill++;
                end
                else
                begin
                    // full miss: drop the oldest
                    for (k = 0; k < SLOT_COUNT - 1; k++)
                        stack_ids[k] = stack_ids[k + 1];
                    stack_ids[SLOT_COUNT - 1] = id;
                end
            end
            for (k = 0; k < SHOWN_SLOTS && k < SLOT_COUNT; k++)
                view.slots[k*ID_W +: ID_W] = stack_ids[k];
            view.occ = (fill > OCC_MAX) ? OCC_W'(OCC_MAX) : OCC_W'(fill);
            expected_views.push_back(view);
        endfunction

        // compare one accepted result with the oldest prediction
        function void check_result(logic [SLOTS_W-1:0] slots, logic [OCC_W-1:0] occ,
                                   logic hit);
            shelf_view_t view;
            if (expected_views.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got slots=%h occ=%0d hit=%0b",
                         $time, slots, occ, hit);
                error_count++;
            end
            else
            begin
                view = expected_views.pop_front();
                if (slots !== view.slots)
                begin
                    $display("%0t: shelf_slots mismatch, expected %h, got %h",
                             $time, view.slots, slots);
                    error_count++;
                end
                if (occ !== view.occ)
                begin
                    $display("%0t: occupied mismatch, expected %0d, got %0d",
                             $time, view.occ, occ);
                    error_count++;
                end
                if (hit !== view.hit)
                begin
                    $display("%0t: was_hit mismatch, expected %0b, got %0b",
                             $time, view.hit, hit);
                    error_count++;
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset and block hookup
    // ------------------------------------------------------------------
    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [ID_W-1:0]    book_id;
    logic               out_valid;
    logic               out_stall;
    logic [SLOTS_W-1:0] shelf_slots;
    logic [OCC_W-1:0]   occupied;
    logic               was_hit;

    shelf_tracker shelf = new();
    int           idle_cycles = 0;

    // warm-up sequence: zero on an empty shelf, single-entry hit, hit in
    // the middle of a partly filled shelf, fill to eight, hit at the newest
    // and at the oldest slot, middle hit when full, eviction, zero when
    // full, all-ones id, alternating bit patterns
    logic [ID_W-1:0] warmup_ids [19] = '{
        8'd0,   8'd1,   8'd1,   8'd255, 8'd2,   8'd255, 8'd128, 8'd64,
        8'd3,   8'd4,   8'd5,   8'd5,   8'd1,   8'd64,  8'd77,  8'd0,
        8'd255, 8'd170, 8'd85
    };

    always #4 clk = ~clk;

    lru_shelf_update_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .book_id     (book_id),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .shelf_slots (shelf_slots),
        .occupied    (occupied),
        .was_hit     (was_hit)
    );

    // ------------------------------------------------------------------
    // idle lengths shared by both sides: mostly short, a few long
    // ------------------------------------------------------------------
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 92)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 50);
    endfunction

    // ------------------------------------------------------------------
    // input side: one access per call, held until the block takes it
    // ------------------------------------------------------------------
    task automatic send_access(input logic [ID_W-1:0] id, input bit no_gaps);
        int gap;
        gap = 0;
        if (!no_gaps && $urandom_range(0, 1) == 0)
            gap = pick_idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        book_id  <= id;
        // the transaction is taken at the first edge with stall low
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // stop sending and wait until every predicted result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        // let the monitor note the last accepted access first
        @(posedge clk);
        while (shelf.pending() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // monitor: note accepted accesses, check accepted results
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                shelf.check_result(shelf_slots, occupied, was_hit);
            if (in_valid && !in_stall)
                shelf.note_access(book_id);
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // result side stall: short and long stalls, now and then a long
    // stretch with no stall at all
    // ------------------------------------------------------------------
    initial
    begin : result_stall_gen
        int quiet;
        int hold;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 9) == 0)
                quiet = $urandom_range(40, 150);
            else
                quiet = $urandom_range(1, 6);
            hold = pick_idle_len();
            repeat (quiet) @(posedge clk);
            out_stall <= 1'b1;
            repeat (hold) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any transaction ends the run
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        @(posedge rst_n);
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [ID_W-1:0] id_pool [16];
        logic [ID_W-1:0] id;
        int              pool_size;
        int              seg_len;
        int              seg_mode;
        int              sent_nonzero;
        int              n;
        bit              tight;
        bit              drained_mid;

        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        book_id  <= EMPTY_ID;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed warm-up
        foreach (warmup_ids[k])
            send_access(warmup_ids[k], 1'b0);
        drain_results();

        // random segments; pool segments revisit ids so hits and
        // evictions dominate, wide segments spread over the whole range
        sent_nonzero = 0;
        drained_mid  = 1'b0;
        while (sent_nonzero < RANDOM_HITS)
        begin
            seg_len   = $urandom_range(20, 80);
            seg_mode  = $urandom_range(0, 9);
            tight     = ($urandom_range(0, 4) == 0);
            pool_size = $urandom_range(4, 14);
            foreach (id_pool[k])
                id_pool[k] = ID_W'($urandom_range(1, 255));
            for (n = 0; n < seg_len; n++)
            begin
                if ($urandom_range(0, 99) < 3)
                    id = EMPTY_ID;
                else if (seg_mode < 7)
                    id = id_pool[$urandom_range(0, pool_size - 1)];
                else
                    id = ID_W'($urandom_range(1, 255));
                send_access(id, tight);
                if (id != EMPTY_ID)
                    sent_nonzero++;
            end
            // halfway, let the block run completely dry once
            if (!drained_mid && sent_nonzero >= RANDOM_HITS / 2)
            begin
                drain_results();
                drained_mid = 1'b1;
            end
        end

        drain_results();
        repeat (SETTLE_TICKS) @(posedge clk);

        if (shelf.error_count == 0 && shelf.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
